FILE: rtl/core/stki_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stki_pkg
// shared types and constants of the sorted top-k insertion list
// ----------------------------------------------------------------------------
package stki_pkg;

  localparam int DEPTH     = 10;
  localparam int TAG_WIDTH = 16;
  localparam int SCORE_W   = 32;
  localparam int RANK_W    = 4;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                   req_type;
    logic signed [SCORE_W-1:0]   score;
    logic [TAG_WIDTH-1:0]        tag;
    logic [RANK_W-1:0]           rank;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0]           placed_at;
    logic                        evicted;
    logic signed [SCORE_W-1:0]   evicted_score;
    logic [TAG_WIDTH-1:0]        evicted_tag;
    logic                        read_valid;
    logic signed [SCORE_W-1:0]   read_score;
    logic [TAG_WIDTH-1:0]        read_tag;
    logic [RANK_W-1:0]           fill_count;
  } rsp_t;

  // per-cell control from the list controller
  typedef struct packed {
    logic ins;      // insert word accepted this cycle
    logic valid;    // cell holds a stored entry
    logic ge_prev;  // upper neighbor keeps its entry
  } cell_ctl_t;

endpackage

FILE: rtl/core/stki_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stki_req_if / stki_rsp_if
// valid/ready channels carrying request and response words
// ----------------------------------------------------------------------------
interface stki_req_if;
  logic          valid;
  logic          ready;
  stki_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stki_rsp_if;
  logic          valid;
  logic          ready;
  stki_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/stki_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stki_cell
// one rank of the list: holds a score and tag, keeps, loads or shifts down
// ----------------------------------------------------------------------------
module stki_cell (
  input  logic                                 clk_i,
  input  stki_pkg::cell_ctl_t                  ctl_i,
  input  logic signed [stki_pkg::SCORE_W-1:0]  new_score_i,
  input  logic [stki_pkg::TAG_WIDTH-1:0]       new_tag_i,
  input  logic signed [stki_pkg::SCORE_W-1:0]  prev_score_i,
  input  logic [stki_pkg::TAG_WIDTH-1:0]       prev_tag_i,
  output logic signed [stki_pkg::SCORE_W-1:0]  score_o,
  output logic [stki_pkg::TAG_WIDTH-1:0]       tag_o,
  output logic                                 ge_o
);

  logic signed [stki_pkg::SCORE_W-1:0] score_q, score_d;
  logic [stki_pkg::TAG_WIDTH-1:0]      tag_q, tag_d;

  // stored entry stays ahead of an equal new score
  assign ge_o = ctl_i.valid && (score_q >= new_score_i);

  always_comb begin
    score_d = score_q;
    tag_d   = tag_q;
    if (ctl_i.ins && !ge_o) begin
      if (ctl_i.ge_prev) begin
        score_d = new_score_i;
        tag_d   = new_tag_i;
      end else begin
        score_d = prev_score_i;
        tag_d   = prev_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    tag_q   <= tag_d;
  end

  assign score_o = score_q;
  assign tag_o   = tag_q;

endmodule

FILE: rtl/core/sorted_top_k_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_top_k_insert
// top-k list of scores with tags, kept in descending order by a cell chain
// ----------------------------------------------------------------------------
// For each accepted word, all cells compare their score with the new one in
// parallel and keep, load or shift down together at the same clock edge,
// and the response word is registered for the next cycle. A new word is
// taken every cycle as long as the response register is free or drained in
// that cycle. Inserts land after all equal scores; when the list is full a
// score at or below the lowest stored one is dropped (placed_at = 10),
// otherwise the lowest entry is evicted and reported. Reads return the
// entry at a rank, with read_valid low beyond the fill count.
module sorted_top_k_insert (
  input  logic        clk_i,
  input  logic        rst_ni,
  stki_req_if.sink    req_i,
  stki_rsp_if.source  rsp_o
);

  localparam int D = stki_pkg::DEPTH;

  logic signed [stki_pkg::SCORE_W-1:0] cell_score [D];
  logic [stki_pkg::TAG_WIDTH-1:0]      cell_tag   [D];
  logic [D-1:0]                        ge;
  logic [D-1:0]                        valid;

  logic [stki_pkg::CNT_W-1:0] fill_q, fill_d;
  logic                       rsp_valid_q;
  stki_pkg::rsp_t             rsp_q, rsp_d;

  logic acc, ins, full, dropped, evict, rd_ok;
  logic [stki_pkg::CNT_W-1:0] pos;
  logic [stki_pkg::IDX_W-1:0] rd_idx;
  logic signed [stki_pkg::SCORE_W-1:0] rd_score;
  logic [stki_pkg::TAG_WIDTH-1:0]      rd_tag;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign ins         = acc && (req_i.data.req_type == stki_pkg::REQ_INSERT);
  assign full        = (fill_q == stki_pkg::CNT_W'(D));

  for (genvar g = 0; g < D; g++) begin : g_cell
    stki_pkg::cell_ctl_t ctl;
    assign ctl.ins     = ins;
    assign ctl.valid   = (stki_pkg::CNT_W'(g) < fill_q);
    assign valid[g]    = ctl.valid;
    if (g == 0) begin : g_head
      assign ctl.ge_prev = 1'b1;
      stki_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl),
        .new_score_i  (req_i.data.score),
        .new_tag_i    (req_i.data.tag),
        .prev_score_i (req_i.data.score),
        .prev_tag_i   (req_i.data.tag),
        .score_o      (cell_score[g]),
        .tag_o        (cell_tag[g]),
        .ge_o         (ge[g])
      );
    end else begin : g_body
      assign ctl.ge_prev = ge[g-1];
      stki_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl),
        .new_score_i  (req_i.data.score),
        .new_tag_i    (req_i.data.tag),
        .prev_score_i (cell_score[g-1]),
        .prev_tag_i   (cell_tag[g-1]),
        .score_o      (cell_score[g]),
        .tag_o        (cell_tag[g]),
        .ge_o         (ge[g])
      );
    end
  end

  // ge is a prefix of ones, so the first clear bit is the insert rank
  always_comb begin
    pos = stki_pkg::CNT_W'(D);
    for (int i = D - 1; i >= 0; i--) begin
      if (!ge[i]) begin
        pos = stki_pkg::CNT_W'(i);
      end
    end
  end

  assign dropped = full && ge[D-1];
  assign evict   = ins && full && !ge[D-1];

  assign rd_idx = stki_pkg::IDX_W'(req_i.data.rank);
  assign rd_ok  = ({{stki_pkg::CNT_W{1'b0}}, req_i.data.rank} <
                   {{stki_pkg::RANK_W{1'b0}}, fill_q});

  always_comb begin
    rd_score = '0;
    rd_tag   = '0;
    for (int i = 0; i < D; i++) begin
      if (rd_idx == stki_pkg::IDX_W'(i)) begin
        rd_score = cell_score[i];
        rd_tag   = cell_tag[i];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ins && !full) begin
      fill_d = fill_q + stki_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    rsp_d            = '0;
    rsp_d.placed_at  = stki_pkg::RANK_W'(D);
    rsp_d.fill_count = stki_pkg::RANK_W'(fill_d);
    if (req_i.data.req_type == stki_pkg::REQ_INSERT) begin
      if (!dropped) begin
        rsp_d.placed_at = stki_pkg::RANK_W'(pos);
      end
      if (evict) begin
        rsp_d.evicted       = 1'b1;
        rsp_d.evicted_score = cell_score[D-1];
        rsp_d.evicted_tag   = cell_tag[D-1];
      end
    end else if (rd_ok) begin
      rsp_d.read_valid = 1'b1;
      rsp_d.read_score = rd_score;
      rsp_d.read_tag   = rd_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (acc) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= stki_pkg::CNT_W'(D))
    else $error("fill count above depth");

  a_read_keeps_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_i.data.req_type == stki_pkg::REQ_READ) |=> $stable(fill_q))
    else $error("read changed fill count");

  a_evict_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict |-> (full && valid[D-1]))
    else $error("eviction from a list that is not full");

  a_word_registered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_valid_q)
    else $error("accepted word produced no response");
`endif

endmodule
